### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the MIDI event list; mel_ctrl uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/mel_pkg.sv
// Package with the types, command codes and constants of the MIDI event list.
package mel_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int CMP_W = 10;
  localparam int LEN_W = 7;
  localparam int POS_W = 6;
  localparam logic [LEN_W-1:0] MAX_LEN_RST = 7'd64;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_DROP   = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;
  localparam logic [2:0] CMD_SEEK   = 3'd5;

  typedef struct packed {
    logic [2:0]       command;
    logic [POS_W-1:0] position;
    logic [7:0]       msg_type;
    logic [3:0]       msg_channel;
    logic [6:0]       note_value;
    logic [6:0]       note_data;
    logic [31:0]      event_tick;
  } in_t;

  typedef struct packed {
    logic             done_ok;
    logic [POS_W-1:0] found_index;
    logic [7:0]       out_type;
    logic [3:0]       out_channel;
    logic [6:0]       out_value;
    logic [6:0]       out_data;
    logic [31:0]      out_tick;
    logic [LEN_W-1:0] list_count;
  } out_t;

  typedef struct packed {
    logic [7:0]  msg_type;
    logic [3:0]  msg_channel;
    logic [6:0]  note_value;
    logic [6:0]  note_data;
    logic [31:0] event_tick;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### hw/rtl/midi_event_ordered_list.sv
// Top level of the MIDI event ordered list: configuration, sequencer, RAM, output register.
//
// Commands arrive on the input channel (in_valid, in_stall, in_item); one
// result per transaction leaves on the output channel (out_valid, out_stall,
// out_item). A transaction is accepted when valid is high and stall is low.
// Entries live in a single simple dual-port RAM with a registered read port.
// Append, clear, refused commands, an insert at the tail and a drop of the last
// entry finish without touching the read port and go from idle straight to the
// done state. Other reads, seeks, inserts and drops sweep the RAM one entry per
// cycle through its read port, writing each shifted entry back in the cycle
// after its read, then pass through the drain state to the done state; an
// insert also passes a final state that writes the new entry.
// The next command is taken once the previous result has moved into the
// output register, so a waiting result does not hold back the next command.
// While out_stall is high the output register holds its transaction and a
// finished result waits inside the sequencer. cfg_write loads max_length (limit
// on entries, capped at DEPTH); the user must use it only when the block is idle,
// which the block does not enforce. Synchronous reset empties the list, sets
// max_length to 64 and clears out_valid; RAM contents stay, no clearing pass is needed.
module midi_event_ordered_list import mel_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_item
);

  logic [LEN_W-1:0] max_length;
  logic             res_valid;
  logic             res_ready;
  out_t             res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  entry_t           mem_rdata;

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LEN_RST;
    end else if (cfg_write) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_item <= res;
    end
  end

  mel_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .max_length(max_length),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  mel_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

### hw/rtl/mel_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/mel_ctrl.sv
// Command sequencer that reads, shifts and writes back list entries in the RAM.
`include "assert_macros.svh"
module mel_ctrl import mel_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] max_length,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_item,
  output logic             res_valid,
  input  logic             res_ready,
  output out_t             res,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output entry_t           mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  entry_t           mem_rdata
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_FIN   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [2:0]    cmd, cmd_next;
  logic [AW-1:0] pos_a, pos_a_next;
  entry_t        ent, ent_next;
  logic [AW-1:0] idx, idx_next;
  logic [AW-1:0] idx_end, idx_end_next;
  logic          rv;
  logic [AW-1:0] raddr_q;
  out_t          result, result_next;

  logic [CMP_W-1:0] cnt_w, pos_w, lim_w, len_w, dep_w;
  entry_t           new_ent;

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign mem_re    = (state == S_SCAN);
  assign mem_raddr = idx;

  always_comb begin
    res = result;
    res.list_count = LEN_W'(count);
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    cmd_next     = cmd;
    pos_a_next   = pos_a;
    ent_next     = ent;
    idx_next     = idx;
    idx_end_next = idx_end;
    result_next  = result;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = ent;
    cnt_w = CMP_W'(count);
    pos_w = CMP_W'(in_item.position);
    len_w = CMP_W'(max_length);
    dep_w = CMP_W'(DEPTH);
    lim_w = (len_w < dep_w) ? len_w : dep_w;
    new_ent = '{msg_type: in_item.msg_type, msg_channel: in_item.msg_channel,
                note_value: in_item.note_value, note_data: in_item.note_data,
                event_tick: in_item.event_tick};

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_next    = in_item.command;
          pos_a_next  = AW'(pos_w);
          ent_next    = new_ent;
          result_next = '0;
          state_next  = S_DONE;
          case (in_item.command)
            CMD_APPEND: begin
              if (cnt_w < lim_w) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cnt_w);
                mem_wdata = new_ent;
                count_next = count + CW'(1);
                result_next.done_ok = 1'b1;
              end
            end
            CMD_INSERT: begin
              if (cnt_w < lim_w && pos_w <= cnt_w) begin
                result_next.done_ok = 1'b1;
                if (pos_w == cnt_w) begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(pos_w);
                  mem_wdata = new_ent;
                  count_next = count + CW'(1);
                end else begin
                  idx_next     = AW'(cnt_w - CMP_W'(1));
                  idx_end_next = AW'(pos_w);
                  state_next   = S_SCAN;
                end
              end
            end
            CMD_DROP: begin
              if (pos_w < cnt_w) begin
                result_next.done_ok = 1'b1;
                if (pos_w == cnt_w - CMP_W'(1)) begin
                  count_next = count - CW'(1);
                end else begin
                  idx_next     = AW'(pos_w + CMP_W'(1));
                  idx_end_next = AW'(cnt_w - CMP_W'(1));
                  state_next   = S_SCAN;
                end
              end
            end
            CMD_CLEAR: begin
              count_next = '0;
              result_next.done_ok = 1'b1;
            end
            CMD_READ: begin
              if (pos_w < cnt_w) begin
                idx_next     = AW'(pos_w);
                idx_end_next = AW'(pos_w);
                state_next   = S_SCAN;
              end
            end
            CMD_SEEK: begin
              if (cnt_w != '0) begin
                idx_next     = '0;
                idx_end_next = AW'(cnt_w - CMP_W'(1));
                state_next   = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (idx == idx_end) begin
          state_next = S_DRAIN;
        end else if (cmd == CMD_INSERT) begin
          idx_next = idx - AW'(1);
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      S_DRAIN: begin
        if (cmd == CMD_INSERT) begin
          state_next = S_FIN;
        end else begin
          if (cmd == CMD_DROP) begin
            count_next = count - CW'(1);
          end
          state_next = S_DONE;
        end
      end
      S_FIN: begin
        mem_we     = 1'b1;
        mem_waddr  = pos_a;
        mem_wdata  = ent;
        count_next = count + CW'(1);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Data returned by the RAM is handled in the cycle after its read.
    if (rv) begin
      case (cmd)
        CMD_INSERT: begin
          mem_we    = 1'b1;
          mem_waddr = raddr_q + AW'(1);
          mem_wdata = mem_rdata;
        end
        CMD_DROP: begin
          mem_we    = 1'b1;
          mem_waddr = raddr_q - AW'(1);
          mem_wdata = mem_rdata;
        end
        CMD_READ: begin
          result_next.done_ok     = 1'b1;
          result_next.out_type    = mem_rdata.msg_type;
          result_next.out_channel = mem_rdata.msg_channel;
          result_next.out_value   = mem_rdata.note_value;
          result_next.out_data    = mem_rdata.note_data;
          result_next.out_tick    = mem_rdata.event_tick;
        end
        CMD_SEEK: begin
          if (mem_rdata.note_value == ent.note_value) begin
            result_next.done_ok     = 1'b1;
            result_next.found_index = POS_W'(raddr_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rv    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rv    <= (state == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    pos_a   <= pos_a_next;
    ent     <= ent_next;
    idx     <= idx_next;
    idx_end <= idx_end_next;
    raddr_q <= idx;
    result  <= result_next;
  end

  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE && !rv && count == '0),
                 "Sequencer not idle and empty after reset")
  `ASSERT_PROP(a_count_bound, clk, rst, CMP_W'(count) <= CMP_W'(DEPTH),
               "Entry count exceeds the memory depth")
  `ASSERT_PROP(a_rv_follows_scan, clk, rst, rv |-> $past(state) == S_SCAN,
               "Read data flagged without a read issued in the previous cycle")
  `ASSERT_PROP(a_no_same_entry, clk, rst, (mem_we && mem_re) |-> mem_waddr != mem_raddr,
               "Write and read of the same entry in one cycle")

endmodule

### tb/event_list_check_pkg.sv
// Scoreboard class that predicts and checks the results of the MIDI event list.
package event_list_check_pkg;
  import mel_pkg::*;

  class event_list_scoreboard;
    entry_t      slots[DEPTH_DEF];
    int unsigned count;
    int unsigned limit;
    out_t        pending_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned cmd_seen[8];

    function new();
      foreach (slots[i]) slots[i] = '0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      count = 0;
      limit = MAX_LEN_RST;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_limit(logic [LEN_W-1:0] v);
      limit = (v > DEPTH_DEF) ? DEPTH_DEF : v;
    endfunction

    function void note_input(in_t it);
      out_t        r;
      entry_t      e;
      int unsigned i;
      int unsigned p;
      r = '0;
      e.msg_type = it.msg_type;
      e.msg_channel = it.msg_channel;
      e.note_value = it.note_value;
      e.note_data = it.note_data;
      e.event_tick = it.event_tick;
      p = it.position;
      cmd_seen[it.command]++;
      case (it.command)
        CMD_APPEND: begin
          if (count < limit) begin
            slots[count] = e;
            count++;
            r.done_ok = 1'b1;
          end
        end
        CMD_INSERT: begin
          if (count < limit && p <= count) begin
            for (i = count; i > p; i--) slots[i] = slots[i-1];
            slots[p] = e;
            count++;
            r.done_ok = 1'b1;
          end
        end
        CMD_DROP: begin
          if (p < count) begin
            for (i = p; i + 1 < count; i++) slots[i] = slots[i+1];
            count--;
            r.done_ok = 1'b1;
          end
        end
        CMD_CLEAR: begin
          count = 0;
          r.done_ok = 1'b1;
        end
        CMD_READ: begin
          if (p < count) begin
            r.out_type = slots[p].msg_type;
            r.out_channel = slots[p].msg_channel;
            r.out_value = slots[p].note_value;
            r.out_data = slots[p].note_data;
            r.out_tick = slots[p].event_tick;
            r.done_ok = 1'b1;
          end
        end
        CMD_SEEK: begin
          for (i = 0; i < count; i++) begin
            if (slots[i].note_value == it.note_value) begin
              r.found_index = i[POS_W-1:0];
              r.done_ok = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.list_count = count[LEN_W-1:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t  exp;
      string bad;
      bad = "";
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transaction %h with nothing pending.", got);
        return;
      end
      exp = pending_q.pop_front();
      if (got.done_ok !== exp.done_ok) bad = {bad, " done_ok"};
      if (got.found_index !== exp.found_index) bad = {bad, " found_index"};
      if (got.out_type !== exp.out_type) bad = {bad, " out_type"};
      if (got.out_channel !== exp.out_channel) bad = {bad, " out_channel"};
      if (got.out_value !== exp.out_value) bad = {bad, " out_value"};
      if (got.out_data !== exp.out_data) bad = {bad, " out_data"};
      if (got.out_tick !== exp.out_tick) bad = {bad, " out_tick"};
      if (got.list_count !== exp.list_count) bad = {bad, " list_count"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch in%s at result %0d: expected %h, got %h.",
                   bad, checked, exp, got);
      end
    endfunction
  endclass

endpackage

### tb/tb.sv
// Testbench top that drives the MIDI event list with directed and random commands.
module tb;
  import mel_pkg::*;
  import event_list_check_pkg::*;

  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [LEN_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_t              in_item = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_item;

  event_list_scoreboard sb = new();
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_ask = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;

  midi_event_ordered_list u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    if (hold_ask != hold_taken) begin
      hold_taken = hold_ask;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_item);
  end

  function automatic in_t mk(logic [2:0] cmd, logic [5:0] pos, logic [7:0] typ,
                             logic [3:0] ch, logic [6:0] val, logic [6:0] dat,
                             logic [31:0] tick);
    in_t it;
    it.command = cmd;
    it.position = pos;
    it.msg_type = typ;
    it.msg_channel = ch;
    it.note_value = val;
    it.note_data = dat;
    it.event_tick = tick;
    return it;
  endfunction

  function automatic in_t next_cmd(int unsigned goal);
    in_t         it;
    int unsigned n;
    int unsigned r;
    n = sb.count;
    it.msg_type = 8'($urandom);
    it.msg_channel = 4'($urandom);
    it.note_value = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 7));
    it.note_data = 7'($urandom);
    it.event_tick = $urandom;
    it.position = 6'($urandom);
    r = $urandom_range(0, 99);
    if (r < 5) begin
      it.command = 3'($urandom);
      return it;
    end
    if (r < 7) begin
      it.command = CMD_CLEAR;
      return it;
    end
    r = $urandom_range(0, 99);
    if (n < goal)
      it.command = (r < 35) ? CMD_APPEND : (r < 60) ? CMD_INSERT : (r < 70) ? CMD_DROP :
                   (r < 85) ? CMD_READ : CMD_SEEK;
    else
      it.command = (r < 10) ? CMD_APPEND : (r < 20) ? CMD_INSERT : (r < 50) ? CMD_DROP :
                   (r < 75) ? CMD_READ : CMD_SEEK;
    if ($urandom_range(0, 9) != 0) begin
      if (it.command == CMD_INSERT)
        it.position = 6'($urandom_range(0, n));
      else if (n > 0 && (it.command == CMD_DROP || it.command == CMD_READ))
        it.position = 6'($urandom_range(0, n - 1));
    end
    if (it.command == CMD_SEEK && n > 0 && $urandom_range(0, 1) == 1)
      it.note_value = sb.slots[$urandom_range(0, n - 1)].note_value;
    return it;
  endfunction

  task automatic push_cmd(input in_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  task automatic sender_gap();
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      while ($urandom_range(0, 99) < idle_pct) @(negedge clk);
    end
  endtask

  task automatic settle(int unsigned extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_max_length(int unsigned v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v[LEN_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_limit(v[LEN_W-1:0]);
  endtask

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned seg_limit[8];
    int unsigned seg_len[8];
    int unsigned goal;
    int unsigned cap;
    seg_limit = '{64, 100, 1, 37, 127, 2, 0, 64};
    seg_len = '{155, 155, 155, 155, 155, 155, 50, 155};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_cmd(mk(CMD_READ, 6'd0, 8'h00, 4'h0, 7'h00, 7'h00, 32'h0));
    push_cmd(mk(CMD_DROP, 6'd0, 8'h00, 4'h0, 7'h00, 7'h00, 32'h0));
    push_cmd(mk(CMD_SEEK, 6'd0, 8'h00, 4'h0, 7'h00, 7'h00, 32'h0));
    push_cmd(mk(CMD_INSERT, 6'd1, 8'h12, 4'h3, 7'h05, 7'h06, 32'h1000));
    push_cmd(mk(CMD_INSERT, 6'd0, 8'hFF, 4'hF, 7'h7F, 7'h7F, 32'hFFFF_FFFF));
    push_cmd(mk(CMD_APPEND, 6'd0, 8'h00, 4'h0, 7'h00, 7'h00, 32'h0));
    push_cmd(mk(CMD_APPEND, 6'd0, 8'h5A, 4'h6, 7'h3C, 7'h40, 32'h1000));
    push_cmd(mk(CMD_INSERT, 6'd1, 8'hA5, 4'h9, 7'h3C, 7'h11, 32'h8000_0001));
    push_cmd(mk(CMD_READ, 6'd0, 8'h00, 4'h0, 7'h00, 7'h00, 32'h0));
    push_cmd(mk(CMD_READ, 6'd3, 8'h00, 4'h0, 7'h00, 7'h00, 32'h0));
    push_cmd(mk(CMD_READ, 6'd63, 8'hFF, 4'hF, 7'h7F, 7'h7F, 32'hFFFF_FFFF));
    push_cmd(mk(CMD_SEEK, 6'd0, 8'h00, 4'h0, 7'h7F, 7'h00, 32'h0));
    push_cmd(mk(CMD_SEEK, 6'd0, 8'h00, 4'h0, 7'h3C, 7'h00, 32'h0));
    push_cmd(mk(CMD_SEEK, 6'd0, 8'h00, 4'h0, 7'h11, 7'h00, 32'h0));
    push_cmd(mk(CMD_DROP, 6'd1, 8'h00, 4'h0, 7'h00, 7'h00, 32'h0));
    push_cmd(mk(CMD_DROP, 6'd63, 8'h00, 4'h0, 7'h00, 7'h00, 32'h0));
    push_cmd(mk(CMD_RSVD6, 6'd63, 8'hFF, 4'hF, 7'h7F, 7'h7F, 32'hFFFF_FFFF));
    push_cmd(mk(CMD_RSVD7, 6'd0, 8'hFF, 4'hF, 7'h7F, 7'h7F, 32'hFFFF_FFFF));
    push_cmd(mk(CMD_INSERT, 6'd3, 8'h81, 4'h1, 7'h01, 7'h7E, 32'h0000_0001));
    push_cmd(mk(CMD_CLEAR, 6'd0, 8'h00, 4'h0, 7'h00, 7'h00, 32'h0));
    push_cmd(mk(CMD_READ, 6'd0, 8'h00, 4'h0, 7'h00, 7'h00, 32'h0));
    settle(4);
    set_max_length(2);
    push_cmd(mk(CMD_APPEND, 6'd0, 8'h11, 4'h2, 7'h21, 7'h31, 32'h1000));
    push_cmd(mk(CMD_APPEND, 6'd0, 8'h22, 4'h4, 7'h22, 7'h32, 32'h2000));
    push_cmd(mk(CMD_APPEND, 6'd0, 8'h33, 4'h8, 7'h23, 7'h33, 32'h3000));
    push_cmd(mk(CMD_INSERT, 6'd0, 8'h44, 4'h5, 7'h24, 7'h34, 32'h4000));
    settle(4);
    set_max_length(0);
    push_cmd(mk(CMD_APPEND, 6'd0, 8'h55, 4'h7, 7'h25, 7'h35, 32'h5000));
    push_cmd(mk(CMD_DROP, 6'd0, 8'h00, 4'h0, 7'h00, 7'h00, 32'h0));
    settle(4);

    for (int s = 0; s < 8; s++) begin
      set_max_length(seg_limit[s]);
      cap = (seg_limit[s] > DEPTH_DEF) ? DEPTH_DEF : seg_limit[s];
      case (s % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      if (s == 0) hold_ask++;
      goal = 0;
      for (int k = 0; k < seg_len[s]; k++) begin
        if (k % 40 == 0) goal = $urandom_range(0, cap);
        sender_gap();
        push_cmd(next_cmd(goal));
      end
      settle(4);
    end

    settle(80);
    $display("Checked %0d result transactions against the prediction.", sb.checked);
    $display("Commands: %0d append, %0d insert, %0d drop, %0d clear, %0d read, %0d seek, %0d other.",
             sb.cmd_seen[CMD_APPEND], sb.cmd_seen[CMD_INSERT], sb.cmd_seen[CMD_DROP],
             sb.cmd_seen[CMD_CLEAR], sb.cmd_seen[CMD_READ], sb.cmd_seen[CMD_SEEK],
             sb.cmd_seen[CMD_RSVD6] + sb.cmd_seen[CMD_RSVD7]);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing.", sb.mismatches, sb.pending_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
